// ===== src/bcw_pkg.sv =====
// Shared constants for the balanced class weight engine.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package bcw_pkg;

  localparam int LABEL_W  = 6;
  localparam int WEIGHT_W = 32;
  localparam int FRAC_W   = 16;

endpackage

`default_nettype wire

// ===== src/balanced_class_weight_engine.sv =====
// Balanced class weight engine top level: command port, scan sequencer, result register.
// Instantiates bcw_hist and bcw_div; uses bcw_pkg.
//
// Input: an item (in_label, in_last) is taken at a rising edge with start high and busy
// low. While loading, busy stays low and one item is taken every cycle. A label at or
// above NUM_CLASSES adds to no count. The item with in_last high ends the set.
// After the last item busy rises. A drain state empties the histogram pipeline, then the
// sequencer walks the bins from label 0 up to the highest present label, each bin in a
// memory read state and a check state. A present bin starts the divider on its check cycle
// and then waits for the divider's done: NW serial divide steps, then the quotient handover,
// where NW = max(clog2(MAX_SAMPLES+1)+16, 33), 33 with the default parameters.
// Output: each weight is shown for one cycle with out_valid high, the cycle after its
// division ends; the receiver cannot stall. out_end_of_run marks the highest present
// class; the histogram clears on the edge that shows it and busy is low in that cycle.
// An empty set gives no result; busy is then high for one cycle only.
// Reset: synchronous active-low rst_n empties the histogram (valid bits cleared), and
// no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module balanced_class_weight_engine #(
  parameter int NUM_CLASSES = 64,
  parameter int MAX_SAMPLES = 65536
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [bcw_pkg::LABEL_W-1:0] in_label,
  input  wire logic                        in_last,
  output logic                             out_valid,
  output logic      [bcw_pkg::LABEL_W-1:0] out_class_label,
  output logic      [bcw_pkg::WEIGHT_W-1:0] out_weight,
  output logic                             out_overflow,
  output logic                             out_end_of_run
);

  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int KW = $clog2(NUM_CLASSES + 1);
  localparam int AW = $clog2(NUM_CLASSES);
  localparam int DW = KW + CW;
  localparam int NW = (CW + bcw_pkg::FRAC_W > bcw_pkg::WEIGHT_W) ?
                      CW + bcw_pkg::FRAC_W : bcw_pkg::WEIGHT_W + 1;

  typedef enum logic [4:0] {
    S_LOAD  = 5'b00001,
    S_DRAIN = 5'b00010,
    S_READ  = 5'b00100,
    S_CHECK = 5'b01000,
    S_DIV   = 5'b10000
  } state_t;

  state_t  state_r, state_nxt;
  logic [AW-1:0] scan_r, scan_nxt;

  logic                          out_valid_r;
  logic [bcw_pkg::LABEL_W-1:0]   out_label_r;
  logic [bcw_pkg::WEIGHT_W-1:0]  out_weight_r;
  logic                          out_ovf_r;
  logic                          out_eor_r;

  logic          acc;
  logic          clr;
  logic          div_start;
  logic          div_done;
  logic [bcw_pkg::WEIGHT_W-1:0] div_quo;
  logic [CW-1:0] cnt;
  logic [CW-1:0] total;
  logic [KW-1:0] k;
  logic          sat;
  logic [AW-1:0] max_lab;
  logic [DW-1:0] den;
  logic [NW-1:0] num;
  logic          is_eor;

  assign busy   = (state_r != S_LOAD);
  assign acc    = start && !busy;
  assign den    = DW'(k) * DW'(cnt);
  assign num    = NW'(total) << bcw_pkg::FRAC_W;
  assign is_eor = (scan_r == max_lab);

  bcw_hist #(
    .NUM_CLASSES (NUM_CLASSES),
    .MAX_SAMPLES (MAX_SAMPLES),
    .CW          (CW),
    .KW          (KW),
    .AW          (AW)
  ) u_hist (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .label     (in_label),
    .scan      (state_r == S_READ),
    .scan_addr (scan_r),
    .clr       (clr),
    .cnt       (cnt),
    .total     (total),
    .k         (k),
    .sat       (sat),
    .max_lab   (max_lab)
  );

  bcw_div #(
    .NW (NW),
    .DW (DW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    state_nxt = state_r;
    scan_nxt  = scan_r;
    clr       = 1'b0;
    div_start = 1'b0;
    unique case (state_r)
      S_LOAD: begin
        if (acc && in_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        scan_nxt = '0;
        if (total == '0) begin
          clr       = 1'b1;
          state_nxt = S_LOAD;
        end else begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (cnt != '0) begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end else if (scan_r == AW'(NUM_CLASSES - 1)) begin
          clr       = 1'b1;
          state_nxt = S_LOAD;
        end else begin
          scan_nxt  = scan_r + AW'(1);
          state_nxt = S_READ;
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (is_eor) begin
            clr       = 1'b1;
            state_nxt = S_LOAD;
          end else begin
            scan_nxt  = scan_r + AW'(1);
            state_nxt = S_READ;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      scan_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_r      <= scan_nxt;
      out_valid_r <= (state_r == S_DIV) && div_done;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_DIV) && div_done) begin
      out_label_r  <= bcw_pkg::LABEL_W'(scan_r);
      out_weight_r <= div_quo;
      out_ovf_r    <= sat;
      out_eor_r    <= is_eor;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_class_label = out_label_r;
  assign out_weight      = out_weight_r;
  assign out_overflow    = out_ovf_r;
  assign out_end_of_run  = out_valid_r && out_eor_r;

  a_out_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_DIV))
    else $error("result beat without a finished division");

  a_last_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_last) |=> busy)
    else $error("busy not raised after the last beat");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside the divide state");

  a_eor_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_end_of_run |-> !busy)
    else $error("end of run seen while still busy");

endmodule

`default_nettype wire

// ===== src/bcw_hist.sv =====
// Class histogram: count memory with valid bits, sample total, class count, max label.
// Two-stage read-modify-write with forwarding; uses bcw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bcw_hist #(
  parameter int NUM_CLASSES = 64,
  parameter int MAX_SAMPLES = 65536,
  parameter int CW = 17,
  parameter int KW = 7,
  parameter int AW = 6
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       acc,
  input  wire logic [bcw_pkg::LABEL_W-1:0] label,
  input  wire logic                       scan,
  input  wire logic [AW-1:0]              scan_addr,
  input  wire logic                       clr,
  output logic      [CW-1:0]              cnt,
  output logic      [CW-1:0]              total,
  output logic      [KW-1:0]              k,
  output logic                            sat,
  output logic      [AW-1:0]              max_lab
);

  logic [CW-1:0]          mem [NUM_CLASSES];
  logic [NUM_CLASSES-1:0] valid_r;
  logic [CW-1:0]          rd_q_r;
  logic [AW-1:0]          rdaddr_r;
  logic                   s1_v_r;
  logic                   fwd_r;
  logic [CW-1:0]          fwd_val_r;
  logic [CW-1:0]          total_r;
  logic [KW-1:0]          k_r;
  logic                   sat_r;
  logic [AW-1:0]          max_r;

  logic                   in_range;
  logic [AW-1:0]          lab_addr;
  logic [AW-1:0]          addr_sel;
  logic [CW-1:0]          old;
  logic                   wr_en;
  logic [CW-1:0]          wr_data;
  logic                   full;

  assign in_range = 32'(label) < NUM_CLASSES;
  assign lab_addr = label[AW-1:0];
  assign addr_sel = scan ? scan_addr : lab_addr;

  always_comb begin
    if (!valid_r[rdaddr_r]) begin
      old = '0;
    end else if (fwd_r) begin
      old = fwd_val_r;
    end else begin
      old = rd_q_r;
    end
  end

  assign full    = old >= CW'(MAX_SAMPLES);
  assign wr_en   = s1_v_r && !full;
  assign wr_data = old + CW'(1);

  always_ff @(posedge clk) begin
    rd_q_r    <= mem[addr_sel];
    rdaddr_r  <= addr_sel;
    fwd_val_r <= wr_data;
    if (wr_en) begin
      mem[rdaddr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      fwd_r   <= 1'b0;
      valid_r <= '0;
      total_r <= '0;
      k_r     <= '0;
      sat_r   <= 1'b0;
      max_r   <= '0;
    end else if (clr) begin
      s1_v_r  <= 1'b0;
      fwd_r   <= 1'b0;
      valid_r <= '0;
      total_r <= '0;
      k_r     <= '0;
      sat_r   <= 1'b0;
      max_r   <= '0;
    end else begin
      s1_v_r <= acc && in_range && !scan;
      fwd_r  <= wr_en && (rdaddr_r == addr_sel);
      if (acc && in_range && !scan) begin
        if (total_r < CW'(MAX_SAMPLES)) begin
          total_r <= total_r + CW'(1);
        end else begin
          sat_r <= 1'b1;
        end
        if (total_r == '0 || lab_addr > max_r) begin
          max_r <= lab_addr;
        end
      end
      if (s1_v_r) begin
        if (full) begin
          sat_r <= 1'b1;
        end else begin
          valid_r[rdaddr_r] <= 1'b1;
          if (old == '0) begin
            k_r <= k_r + KW'(1);
          end
        end
      end
    end
  end

  assign cnt     = old;
  assign total   = total_r;
  assign k       = k_r;
  assign sat     = sat_r;
  assign max_lab = max_r;

endmodule

`default_nettype wire

// ===== src/bcw_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle, 32-bit saturated result.
// Uses bcw_pkg for the result width.
`timescale 1ns / 1ps
`default_nettype none

module bcw_div #(
  parameter int NW = 36,
  parameter int DW = 24
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [NW-1:0]               num,
  input  wire logic [DW-1:0]               den,
  output logic                             done,
  output logic      [bcw_pkg::WEIGHT_W-1:0] quo
);

  localparam int CTW = $clog2(NW + 1);

  logic [DW-1:0]  rem_r;
  logic [NW-1:0]  q_r;
  logic [DW-1:0]  den_r;
  logic [CTW-1:0] ctr_r;
  logic           run_r;
  logic           done_r;

  logic [DW:0]    shifted;
  logic [DW:0]    dext;
  logic [DW:0]    diff;
  logic           ge;

  assign shifted = {rem_r, q_r[NW-1]};
  assign dext    = {1'b0, den_r};
  assign ge      = shifted >= dext;
  assign diff    = shifted - dext;

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= num;
      den_r <= den;
    end else if (run_r) begin
      rem_r <= ge ? diff[DW-1:0] : shifted[DW-1:0];
      q_r   <= {q_r[NW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      ctr_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        ctr_r <= CTW'(NW);
      end else if (run_r) begin
        ctr_r <= ctr_r - CTW'(1);
        if (ctr_r == CTW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = (|q_r[NW-1:bcw_pkg::WEIGHT_W]) ? '1 : q_r[bcw_pkg::WEIGHT_W-1:0];

endmodule

`default_nettype wire
